### hdl/dimp_pkg.sv
// dimp_pkg: shared types and constants of the depth image to point cloud block
// no dependencies; imported by every module of the block

package dimp_pkg;

	// configuration register indexes
	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_COL_SCALE    = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_ROW_SCALE    = 2'd3;

	// register values after reset
	localparam int RST_IMAGE_WIDTH  = 320;
	localparam int RST_IMAGE_HEIGHT = 240;
	localparam int RST_COL_SCALE    = 29142;
	localparam int RST_ROW_SCALE    = 29142;

	// width of a projected coordinate
	localparam int COORD_W = 32;

	// log2 of the number of entries in the queue between front and back
	localparam int QUEUE_AW = 2;

	// per-pixel flags passed from the front to the back
	typedef struct packed {
		logic row_neg;
		logic col_neg;
		logic frame_last;
	} pix_ctl_t;

endpackage

### hdl/dimp_front.sv
// dimp_front: pixel position counters and offset classification
// depends on dimp_pkg

module dimp_front #(
	parameter int DEPTH_BITS = 16,
	parameter int DIM_BITS   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [DEPTH_BITS-1:0] depth,
	input  logic [DIM_BITS:0]     image_width,
	input  logic [DIM_BITS:0]     image_height,
	input  logic                  queue_full,
	output logic                  queue_wr,
	output logic [DEPTH_BITS-1:0] queue_depth,
	output logic [DIM_BITS:0]     row_mag,
	output logic [DIM_BITS:0]     col_mag,
	output dimp_pkg::pix_ctl_t    ctl
);
	import dimp_pkg::*;

	localparam int DW = DIM_BITS + 1;
	localparam logic [DW-1:0] DIM_MAX = {1'b1, {DIM_BITS{1'b0}}};

	logic [DIM_BITS-1:0] col_q;
	logic [DIM_BITS-1:0] row_q;
	logic [DW-1:0]       w_eff;
	logic [DW-1:0]       h_eff;
	logic [DW-1:0]       w_last;
	logic [DW-1:0]       h_last;
	logic                col_end;
	logic                row_end;
	logic signed [DW:0]  col_off;
	logic signed [DW:0]  row_off;
	logic signed [DW:0]  col_off_n;
	logic signed [DW:0]  row_off_n;

	// zero dimension acts as one, oversized clamps to the counter range
	always_comb begin
		if (image_width == '0) begin
			w_eff = DW'(1);
		end else if (image_width > DIM_MAX) begin
			w_eff = DIM_MAX;
		end else begin
			w_eff = image_width;
		end
		if (image_height == '0) begin
			h_eff = DW'(1);
		end else if (image_height > DIM_MAX) begin
			h_eff = DIM_MAX;
		end else begin
			h_eff = image_height;
		end
	end

	assign w_last  = w_eff - DW'(1);
	assign h_last  = h_eff - DW'(1);
	assign col_end = {1'b0, col_q} >= w_last;
	assign row_end = {1'b0, row_q} >= h_last;

	// signed offsets 2*count - (dim-1), split into sign and magnitude
	assign col_off   = $signed({1'b0, col_q, 1'b0}) - $signed({1'b0, w_last});
	assign row_off   = $signed({1'b0, row_q, 1'b0}) - $signed({1'b0, h_last});
	assign col_off_n = -col_off;
	assign row_off_n = -row_off;

	assign col_mag = col_off[DW] ? col_off_n[DW-1:0] : col_off[DW-1:0];
	assign row_mag = row_off[DW] ? row_off_n[DW-1:0] : row_off[DW-1:0];

	assign ctl.row_neg    = row_off[DW];
	assign ctl.col_neg    = col_off[DW];
	assign ctl.frame_last = col_end && row_end;

	assign queue_wr    = push && !queue_full;
	assign queue_depth = depth;

	// raster position, advanced on every input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (queue_wr) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + DIM_BITS'(1);
			end else begin
				col_q <= col_q + DIM_BITS'(1);
			end
		end
	end

endmodule

### hdl/dimp_queue.sv
// dimp_queue: small first-in first-out queue between front and back
// depends on dimp_pkg

module dimp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	import dimp_pkg::*;

	localparam int ENTRIES = 1 << QUEUE_AW;

	logic [WIDTH-1:0]    mem_q [ENTRIES];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = count_q == (QUEUE_AW+1)'(ENTRIES);
	assign empty   = count_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

### hdl/dimp_proj.sv
// dimp_proj: one coordinate lane, depth*scale, times offset, round and saturate
// depends on dimp_pkg

module dimp_proj #(
	parameter int DEPTH_BITS      = 16,
	parameter int DIM_BITS        = 12,
	parameter int SCALE_FRAC_BITS = 24
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [DEPTH_BITS-1:0]             depth,
	input  logic [SCALE_FRAC_BITS-1:0]        scale,
	input  logic [DIM_BITS:0]                 mag,
	input  logic                              neg,
	output logic signed [dimp_pkg::COORD_W-1:0] coord
);
	import dimp_pkg::*;

	localparam int P1W = DEPTH_BITS + SCALE_FRAC_BITS;
	localparam int PW  = P1W + DIM_BITS + 1;
	localparam int QB  = PW + 1 - SCALE_FRAC_BITS;
	localparam int QW  = (QB > COORD_W + 1) ? QB : COORD_W + 1;
	localparam logic [PW:0]   RND     = (PW+1)'(1) << (SCALE_FRAC_BITS - 1);
	localparam logic [QW-1:0] LIM_POS = (QW'(1) << (COORD_W - 1)) - QW'(1);
	localparam logic [QW-1:0] LIM_NEG = QW'(1) << (COORD_W - 1);

	logic [P1W-1:0]     prod_s1;
	logic [DIM_BITS:0]  mag_s1;
	logic               neg_s1;
	logic [PW-1:0]      prod_s2;
	logic               neg_s2;
	logic [PW:0]        sum;
	logic [QW-1:0]      quo;
	logic [QW-1:0]      lim;
	logic [QW-1:0]      sat;
	logic [COORD_W-1:0] sat_n;
	logic [COORD_W-1:0] coord_s3;

	// stage 1: depth times Q0.F scale
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= P1W'(depth) * P1W'(scale);
			mag_s1  <= mag;
			neg_s1  <= neg;
		end
	end

	// stage 2: times offset magnitude, exact product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PW'(prod_s1) * PW'(mag_s1);
			neg_s2  <= neg_s1;
		end
	end

	// round half away from zero on the magnitude, clamp, then apply the sign
	always_comb begin
		sum   = {1'b0, prod_s2} + RND;
		quo   = QW'(sum[PW:SCALE_FRAC_BITS]);
		lim   = neg_s2 ? LIM_NEG : LIM_POS;
		sat   = (quo > lim) ? lim : quo;
		sat_n = -sat[COORD_W-1:0];
	end

	// stage 3: result register
	always_ff @(posedge clk) begin
		if (en) begin
			coord_s3 <= neg_s2 ? sat_n : sat[COORD_W-1:0];
		end
	end

	assign coord = $signed(coord_s3);

endmodule

### hdl/dimp_back.sv
// dimp_back: three-stage projection pipeline drained from the queue
// depends on dimp_pkg and dimp_proj

module dimp_back #(
	parameter int DEPTH_BITS      = 16,
	parameter int DIM_BITS        = 12,
	parameter int SCALE_FRAC_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                queue_empty,
	output logic                                queue_rd,
	input  logic [DEPTH_BITS-1:0]               depth,
	input  logic [DIM_BITS:0]                   row_mag,
	input  logic [DIM_BITS:0]                   col_mag,
	input  dimp_pkg::pix_ctl_t                  ctl,
	input  logic [SCALE_FRAC_BITS-1:0]          row_scale,
	input  logic [SCALE_FRAC_BITS-1:0]          col_scale,
	input  logic                                pop,
	output logic                                empty,
	output logic signed [dimp_pkg::COORD_W-1:0] point_x,
	output logic signed [dimp_pkg::COORD_W-1:0] point_y,
	output logic [DEPTH_BITS-1:0]               point_z,
	output logic                                frame_last
);
	import dimp_pkg::*;

	logic                  adv;
	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic [DEPTH_BITS-1:0] depth_s1;
	logic [DEPTH_BITS-1:0] depth_s2;
	logic [DEPTH_BITS-1:0] depth_s3;
	logic                  last_s1;
	logic                  last_s2;
	logic                  last_s3;

	// whole pipeline moves unless a finished result waits untaken
	assign adv      = !valid_s3 || pop;
	assign queue_rd = adv && !queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= !queue_empty;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// depth and frame flag ride along with the lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			depth_s1 <= depth;
			depth_s2 <= depth_s1;
			depth_s3 <= depth_s2;
			last_s1  <= ctl.frame_last;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
		end
	end

	dimp_proj #(
		.DEPTH_BITS      (DEPTH_BITS),
		.DIM_BITS        (DIM_BITS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_row (
		.clk   (clk),
		.en    (adv),
		.depth (depth),
		.scale (row_scale),
		.mag   (row_mag),
		.neg   (ctl.row_neg),
		.coord (point_x)
	);

	dimp_proj #(
		.DEPTH_BITS      (DEPTH_BITS),
		.DIM_BITS        (DIM_BITS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_col (
		.clk   (clk),
		.en    (adv),
		.depth (depth),
		.scale (col_scale),
		.mag   (col_mag),
		.neg   (ctl.col_neg),
		.coord (point_y)
	);

	assign empty      = !valid_s3;
	assign point_z    = depth_s3;
	assign frame_last = last_s3;

endmodule

### hdl/depth_image_to_point_cloud.sv
// depth_image_to_point_cloud: top level, configuration registers and wiring
// depends on dimp_pkg, dimp_front, dimp_queue and dimp_back

// Depth pixels enter in raster order, one per transfer, and each yields one
// camera-space point (point_x from the row offset, point_y from the column
// offset, point_z the depth itself) plus a flag on the last pixel of the frame.
// The block sustains one pixel per clock while results are popped. A pixel
// passes the front, which classifies it into a four-entry queue, then the
// back, which runs two multiply stages (depth times scale, then times the
// pixel offset) and a round-and-saturate stage per coordinate. The result
// stage holds while pop is low; the queue then absorbs pixels until its four
// entries are taken and full rises. Write configuration only while no pixel
// is in flight; the pixel counters are not reset by configuration writes.

module depth_image_to_point_cloud #(
	parameter int DEPTH_BITS      = 16,
	parameter int DIM_BITS        = 12,
	parameter int SCALE_FRAC_BITS = 24,
	localparam int CFG_W = (DIM_BITS + 1 > SCALE_FRAC_BITS) ? DIM_BITS + 1 : SCALE_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [DEPTH_BITS-1:0]               depth,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [dimp_pkg::COORD_W-1:0] point_x,
	output logic signed [dimp_pkg::COORD_W-1:0] point_y,
	output logic [DEPTH_BITS-1:0]               point_z,
	output logic                                frame_last,
	input  logic                                cfg_wr,
	input  logic [dimp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]                    cfg_data
);
	import dimp_pkg::*;

	localparam int DW = DIM_BITS + 1;
	localparam int QD = DEPTH_BITS + 2 * DW + $bits(pix_ctl_t);

	logic [DW-1:0]              image_width_q;
	logic [DW-1:0]              image_height_q;
	logic [SCALE_FRAC_BITS-1:0] col_scale_q;
	logic [SCALE_FRAC_BITS-1:0] row_scale_q;

	logic                  q_wr;
	logic                  q_rd;
	logic                  q_full;
	logic                  q_empty;
	logic [QD-1:0]         q_wr_data;
	logic [QD-1:0]         q_rd_data;
	logic [DEPTH_BITS-1:0] f_depth;
	logic [DW-1:0]         f_row_mag;
	logic [DW-1:0]         f_col_mag;
	pix_ctl_t              f_ctl;
	logic [DEPTH_BITS-1:0] b_depth;
	logic [DW-1:0]         b_row_mag;
	logic [DW-1:0]         b_col_mag;
	pix_ctl_t              b_ctl;

	// configuration registers, upper data bits dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DW'(RST_IMAGE_WIDTH);
			image_height_q <= DW'(RST_IMAGE_HEIGHT);
			col_scale_q    <= SCALE_FRAC_BITS'(RST_COL_SCALE);
			row_scale_q    <= SCALE_FRAC_BITS'(RST_ROW_SCALE);
		end else if (cfg_wr) begin
			case (cfg_addr)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DW-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[DW-1:0];
				CFG_COL_SCALE:    col_scale_q    <= cfg_data[SCALE_FRAC_BITS-1:0];
				CFG_ROW_SCALE:    row_scale_q    <= cfg_data[SCALE_FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	dimp_front #(
		.DEPTH_BITS (DEPTH_BITS),
		.DIM_BITS   (DIM_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.depth        (depth),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.queue_full   (q_full),
		.queue_wr     (q_wr),
		.queue_depth  (f_depth),
		.row_mag      (f_row_mag),
		.col_mag      (f_col_mag),
		.ctl          (f_ctl)
	);

	assign q_wr_data = {f_depth, f_row_mag, f_col_mag, f_ctl};
	assign full      = q_full;

	dimp_queue #(
		.WIDTH (QD)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	assign {b_depth, b_row_mag, b_col_mag, b_ctl} = q_rd_data;

	dimp_back #(
		.DEPTH_BITS      (DEPTH_BITS),
		.DIM_BITS        (DIM_BITS),
		.SCALE_FRAC_BITS (SCALE_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.queue_rd    (q_rd),
		.depth       (b_depth),
		.row_mag     (b_row_mag),
		.col_mag     (b_col_mag),
		.ctl         (b_ctl),
		.row_scale   (row_scale_q),
		.col_scale   (col_scale_q),
		.pop         (pop),
		.empty       (empty),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.frame_last  (frame_last)
	);

endmodule

### hdl/dimp_check.sv
// dimp_check: port-level assertions for depth_image_to_point_cloud
// depends on dimp_pkg; bound to the top level at the end of this file

module dimp_check #(
	parameter int DEPTH_BITS = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                full,
	input logic                                empty,
	input logic                                pop,
	input logic signed [dimp_pkg::COORD_W-1:0] point_x,
	input logic signed [dimp_pkg::COORD_W-1:0] point_y,
	input logic [DEPTH_BITS-1:0]               point_z,
	input logic                                frame_last
);
	import dimp_pkg::*;

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable({point_x, point_y, point_z, frame_last}))
		else $error("result changed while waiting");

	// zero depth projects to the origin
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && point_z == '0 |-> point_x == '0 && point_y == '0)
		else $error("nonzero coordinate for zero depth");

	// the queue only fills while a result is held back
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input blocked with no result waiting");

	// nothing waits and nothing blocks right after reset
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty && !full)
		else $error("block not idle after reset");

endmodule

bind depth_image_to_point_cloud dimp_check #(.DEPTH_BITS(DEPTH_BITS)) u_dimp_check (.*);
